[rtl/core/bpa_pkg.sv]
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

	localparam int NUM_PAGES_DEF  = 65536;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int WORD_BITS      = 64;
	localparam int ADDR_W         = 64;
	localparam int COUNT_W        = 17;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_RESERVE = 2'd3
	} bpa_op_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_NO_RUN = 2'd1,
		STATUS_ZERO   = 2'd2,
		STATUS_RANGE  = 2'd3
	} bpa_status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_SCAN_START,
		S_SCAN,
		S_RD,
		S_WR,
		S_DONE
	} bpa_state_t;

	// Summary of the free pages in one bitmap word.
	typedef struct packed {
		logic [6:0] free_low;   // free pages counted up from bit 0
		logic [6:0] free_high;  // free pages counted down from bit 63
		logic       run_hit;    // a run of the asked length lies inside the word
		logic [5:0] run_pos;    // lowest start of such a run
	} bpa_word_eval_t;

endpackage

[rtl/core/bpa_if.sv]
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if import bpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [COUNT_W-1:0] page_count;
	logic [ADDR_W-1:0]  address;

	modport source (output valid, output opcode, output page_count, output address,
		input ready);
	modport sink (input valid, input opcode, input page_count, input address,
		output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] result_address;

	modport source (output valid, output status, output result_address, input ready);
	modport sink (input valid, input status, input result_address, output ready);
endinterface

[rtl/core/bpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/bpa_word_eval.sv]
// Free-run evaluation of one 64-bit bitmap word for the first-fit scan.
module bpa_word_eval import bpa_pkg::*; (
	input  logic [WORD_BITS-1:0] free_bits,
	input  logic [5:0]           run_len,
	output bpa_word_eval_t       res
);

	logic [WORD_BITS-1:0] runs;

	always_comb begin
		logic [WORD_BITS-1:0] span;
		int                   sh;
		span = free_bits;
		runs = '1;
		sh   = 0;
		// span holds the starts of free runs of length 2**b; runs collects
		// the starts of free runs of length run_len, built bit by bit.
		for (int b = 0; b < 6; b++) begin
			if (run_len[b]) begin
				runs = runs & (span >> sh);
				sh   = sh + (1 << b);
			end
			span = span & (span >> (1 << b));
		end
	end

	always_comb begin
		res.free_low  = 7'd64;
		res.free_high = 7'd64;
		res.run_pos   = '0;
		res.run_hit   = |runs;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!free_bits[i]) begin
				res.free_low = 7'(i);
			end
			if (runs[i]) begin
				res.run_pos = 6'(i);
			end
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!free_bits[i]) begin
				res.free_high = 7'(WORD_BITS - 1 - i);
			end
		end
	end

endmodule

[rtl/core/bitmap_page_allocator.sv]
// Top level of the bitmap first-fit contiguous page allocator.
//
//   channel   direction  handshake          payload
//   req       in         valid/ready        opcode, page_count, address
//   rsp       out        valid/ready        status, result_address
//   cfg       in         cfg_wr_en          cfg_wr_data (virtual_base)
//
// The bitmap lives in one RAM of 64-bit words, one bit per page.
// After reset a clearing pass writes all ones to every word; no request
// is taken meanwhile. Allocate scans one word per cycle through the RAM read
// port, after the setup states S_PREP and S_SCAN_START. Every range operation then
// reads and then writes each touched word. One request is in flight at a time; the
// next is taken after the response transfer. Page size must be a power of two.
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int NUM_PAGES  = NUM_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bpa_req_if.sink           req,
	bpa_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data
);

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PG_W      = WA_W + 6;
	localparam int CNT_BITS  = $clog2(NUM_PAGES + 1);
	localparam int RUN_W     = ((CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W) + 1;
	localparam int SHIFT     = $clog2(PAGE_BYTES);
	localparam int TAIL      = NUM_PAGES % WORD_BITS;
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);
	localparam logic [WORD_BITS-1:0] TAIL_MASK =
		(TAIL == 0) ? '1 : ((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));

	bpa_state_t         state_q, state_d;
	logic [ADDR_W-1:0]  vbase_q;
	bpa_op_t            op_q;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [WA_W-1:0]    word_q;
	logic [RUN_W-1:0]   carry_run_q;
	logic [PG_W-1:0]    carry_first_q;
	logic [PG_W-1:0]    first_page_q;
	logic [PG_W-1:0]    last_page_q;
	logic               set_q;
	logic               rsp_valid_q;
	logic [1:0]         rsp_status_q;
	logic [ADDR_W-1:0]  rsp_addr_q;

	logic                 ram_we;
	logic [WA_W-1:0]      ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WA_W-1:0]      ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	bpa_word_eval_t       eval_res;
	logic [WORD_BITS-1:0] free_w;
	logic [PG_W-1:0]      word_base;
	logic [RUN_W-1:0]     run_sum;
	logic                 hit_carry;
	logic                 found;
	logic [PG_W-1:0]      found_start;
	logic [PG_W-1:0]      found_last;

	logic [ADDR_W-1:0]    first_full;
	logic                 fits;
	logic                 last_wr;
	logic [5:0]           lo_bit;
	logic [5:0]           hi_bit;
	logic [WORD_BITS-1:0] wr_mask;

	logic                 finish;
	bpa_status_t          fin_status;
	logic [ADDR_W-1:0]    fin_addr;

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Padding pages past the end of the map always look used.
	assign free_w = ~ram_rdata & ((word_q == LAST_WORD) ? TAIL_MASK : '1);

	bpa_word_eval u_eval (
		.free_bits (free_w),
		.run_len   (count_q[5:0]),
		.res       (eval_res)
	);

	assign word_base   = {word_q, 6'd0};
	assign run_sum     = carry_run_q + RUN_W'(eval_res.free_low);
	assign hit_carry   = run_sum >= RUN_W'(count_q);
	assign found       = hit_carry || ((count_q < COUNT_W'(WORD_BITS)) && eval_res.run_hit);
	assign found_start = hit_carry ?
		((carry_run_q == '0) ? word_base : carry_first_q) : {word_q, eval_res.run_pos};
	assign found_last  = found_start + PG_W'(count_q) - PG_W'(1);

	assign first_full = addr_q >> SHIFT;
	assign fits = (first_full < ADDR_W'(NUM_PAGES)) &&
		(ADDR_W'(count_q) <= ADDR_W'(NUM_PAGES) - first_full);

	assign last_wr = (word_q == last_page_q[PG_W-1:6]);
	assign lo_bit  = (word_q == first_page_q[PG_W-1:6]) ? first_page_q[5:0] : 6'd0;
	assign hi_bit  = last_wr ? last_page_q[5:0] : 6'd63;
	assign wr_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_bit));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.result_address = rsp_addr_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (word_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				priority if (count_q == '0) begin
					state_d = S_DONE;
				end else if (op_q == OP_ALLOC) begin
					state_d = (RUN_W'(count_q) > RUN_W'(NUM_PAGES)) ? S_DONE : S_SCAN_START;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK:      state_d = fits ? S_RD : S_DONE;
			S_SCAN_START: state_d = S_SCAN;
			S_SCAN: begin
				priority if (found) begin
					state_d = S_RD;
				end else if (word_q == LAST_WORD) begin
					state_d = S_DONE;
				end
			end
			S_RD: state_d = S_WR;
			S_WR: state_d = last_wr ? S_DONE : S_RD;
			S_DONE: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM control and response values.
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = word_q;
		ram_wdata  = '1;
		ram_raddr  = word_q;
		finish     = 1'b0;
		fin_status = STATUS_OK;
		fin_addr   = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_PREP: begin
				priority if (count_q == '0) begin
					finish     = 1'b1;
					fin_status = STATUS_ZERO;
				end else if (op_q == OP_ALLOC && RUN_W'(count_q) > RUN_W'(NUM_PAGES)) begin
					finish     = 1'b1;
					fin_status = STATUS_NO_RUN;
				end else begin
					finish = 1'b0;
				end
			end
			S_CHECK: begin
				if (!fits) begin
					finish     = 1'b1;
					fin_status = STATUS_RANGE;
				end
			end
			S_SCAN: begin
				ram_raddr = word_q + WA_W'(1);
				if (!found && word_q == LAST_WORD) begin
					finish     = 1'b1;
					fin_status = STATUS_NO_RUN;
				end
			end
			S_WR: begin
				ram_we    = 1'b1;
				ram_wdata = set_q ? (ram_rdata | wr_mask) : (ram_rdata & ~wr_mask);
				if (last_wr) begin
					finish = 1'b1;
					if (op_q == OP_ALLOC) begin
						fin_addr = (ADDR_W'(first_page_q) << SHIFT) + vbase_q;
					end
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			word_q      <= '0;
			vbase_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				vbase_q <= cfg_wr_data;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: word_q <= word_q + WA_W'(1);
				S_PREP:  word_q <= '0;
				S_CHECK: word_q <= first_full[PG_W-1:6];
				S_SCAN: begin
					priority if (found) begin
						word_q <= found_start[PG_W-1:6];
					end else begin
						word_q <= word_q + WA_W'(1);
					end
				end
				S_WR: word_q <= word_q + WA_W'(1);
				default: word_q <= word_q;
			endcase
		end
	end

	// Request payload and working registers.
	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_status_q <= fin_status;
			rsp_addr_q   <= fin_addr;
		end
		unique case (state_q)
			S_IDLE: begin
				op_q    <= bpa_op_t'(req.opcode);
				count_q <= req.page_count;
				addr_q  <= req.address;
			end
			S_PREP: begin
				carry_run_q <= '0;
				if (op_q == OP_FREE) begin
					addr_q <= addr_q - vbase_q;
				end
			end
			S_CHECK: begin
				first_page_q <= first_full[PG_W-1:0];
				last_page_q  <= PG_W'(first_full + ADDR_W'(count_q) - ADDR_W'(1));
				set_q        <= (op_q == OP_RESERVE);
			end
			S_SCAN: begin
				priority if (found) begin
					first_page_q <= found_start;
					last_page_q  <= found_last;
					set_q        <= 1'b1;
				end else if (eval_res.free_low == 7'd64) begin
					// A wholly free word extends the open run.
					carry_run_q <= carry_run_q + RUN_W'(WORD_BITS);
					if (carry_run_q == '0) begin
						carry_first_q <= word_base;
					end
				end else begin
					carry_run_q   <= RUN_W'(eval_res.free_high);
					carry_first_q <= word_base + PG_W'(7'd64 - eval_res.free_high);
				end
			end
			default: begin
				set_q <= set_q;
			end
		endcase
	end

endmodule
